// ===== sv/fue_pkg.sv =====
// ----------------------------------------------------------------------------
// fue_pkg
// Shared types, character codes and helpers for the form body decoder.
// ----------------------------------------------------------------------------
package fue_pkg;

    // character codes
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    // escape phase codes
    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_TWO  = 2'd2;

    // most results one input item can cause
    localparam int MAX_RUN = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_body;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_value;
        logic       pair_end;
        logic       pair_kept;
        logic       body_end;
        logic       run_last;
    } t_out_item;

    // one result without its run flags
    typedef struct packed {
        logic [7:0] data;
        logic       val;
        logic       marker;
        logic       kept;
    } t_slot;

    // all results caused by one input item
    typedef struct packed {
        t_slot [MAX_RUN-1:0] slots;
        logic [1:0]          cnt;
        logic                eob;
    } t_bundle;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    function automatic t_slot mk_slot(input logic [7:0] data, input logic val,
                                      input logic marker, input logic kept);
        t_slot s;
        s.data   = data;
        s.val    = val;
        s.marker = marker;
        s.kept   = kept;
        return s;
    endfunction

    // pending escape emitted as literal percent or single digit value
    function automatic t_slot flush_slot(input logic [1:0] phase, input logic [7:0] held,
                                         input logic val);
        logic [7:0] d;
        d = (phase == PH_ONE) ? CH_PCT : {4'h0, hex_nib(held)};
        return mk_slot(d, val, 1'b0, 1'b0);
    endfunction

endpackage

// ===== sv/form_urlencoded_decoder.sv =====
// ----------------------------------------------------------------------------
// form_urlencoded_decoder
// Percent decoder for a form body: key and value bytes tagged, pair markers.
// ----------------------------------------------------------------------------
// path: each result goes through the bundle queue and then the output register
// throughput: one input item per cycle while items cause at most one result
//   and the output is popped; results leave at one per cycle while popped, so
//   the extra results of an item are absorbed by the bundle queue (QUEUE_DEPTH entries)
// reset: synchronous, active low; clears pair state, queue and output valid
module form_urlencoded_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  fue_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output fue_pkg::t_out_item o_result
);
    import fue_pkg::*;

    logic    accept;
    logic    bvalid;
    t_bundle bundle;
    t_bundle head;
    logic    qfull;
    logic    qempty;
    logic    qpop;

    assign accept = push && !qfull;
    assign full   = qfull;

    fue_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_bvalid (bvalid),
        .o_bundle (bundle)
    );

    fue_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (bvalid),
        .i_wdata (bundle),
        .i_rd    (qpop),
        .o_head  (head),
        .o_full  (qfull),
        .o_empty (qempty)
    );

    fue_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_qempty (qempty),
        .o_qpop   (qpop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (o_result)
    );

endmodule

// ===== sv/fue_front.sv =====
// ----------------------------------------------------------------------------
// fue_front
// Accepts raw body bytes, tracks pair and escape state and forms the bundle
// of results that each byte causes.
// ----------------------------------------------------------------------------
module fue_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  fue_pkg::t_in_item i_item,
    output logic              o_bvalid,
    output fue_pkg::t_bundle  o_bundle
);
    import fue_pkg::*;

    logic       r_ivp, n_ivp;
    logic [1:0] r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       r_ne, n_ne;

    t_slot [MAX_RUN-1:0] slots;
    logic [1:0]          cnt;
    logic                plain;
    logic [7:0]          b;
    logic                eob;

    assign b   = i_item.in_byte;
    assign eob = i_item.end_of_body;

    // classify the byte and build its results
    always_comb begin
        n_ivp   = r_ivp;
        n_phase = r_phase;
        n_held  = r_held;
        n_ne    = r_ne;
        slots   = '0;
        cnt     = 2'd0;
        plain   = 1'b1;
        if (b == CH_AMP) begin
            if (r_phase != PH_NONE) begin
                slots[cnt] = flush_slot(r_phase, r_held, r_ivp);
                cnt = cnt + 2'd1;
            end
            if (r_ne) begin
                slots[cnt] = mk_slot(8'h00, 1'b0, 1'b1, r_ivp);
                cnt = cnt + 2'd1;
            end
            n_ivp   = 1'b0;
            n_phase = PH_NONE;
            n_ne    = 1'b0;
        end else begin
            n_ne = 1'b1;
            case (r_phase)
                PH_ONE: begin
                    if (is_hex(b)) begin
                        n_held  = b;
                        n_phase = PH_TWO;
                        plain   = 1'b0;
                    end else begin
                        slots[cnt] = flush_slot(r_phase, r_held, r_ivp);
                        cnt = cnt + 2'd1;
                        n_phase = PH_NONE;
                    end
                end
                PH_TWO: begin
                    if (is_hex(b)) begin
                        slots[cnt] = mk_slot({hex_nib(r_held), hex_nib(b)}, r_ivp,
                                             1'b0, 1'b0);
                        cnt = cnt + 2'd1;
                        plain = 1'b0;
                    end else begin
                        slots[cnt] = flush_slot(r_phase, r_held, r_ivp);
                        cnt = cnt + 2'd1;
                    end
                    n_phase = PH_NONE;
                end
                default: ;
            endcase
            if (plain) begin
                if (b == CH_PCT) begin
                    n_phase = PH_ONE;
                end else if (b == CH_EQ && !r_ivp) begin
                    n_ivp = 1'b1;
                end else if (b == CH_PLUS) begin
                    slots[cnt] = mk_slot(CH_SPACE, r_ivp, 1'b0, 1'b0);
                    cnt = cnt + 2'd1;
                end else begin
                    slots[cnt] = mk_slot(b, r_ivp, 1'b0, 1'b0);
                    cnt = cnt + 2'd1;
                end
            end
            // end of body closes the open pair
            if (eob) begin
                if (n_phase != PH_NONE) begin
                    slots[cnt] = flush_slot(n_phase, n_held, n_ivp);
                    cnt = cnt + 2'd1;
                end
                slots[cnt] = mk_slot(8'h00, 1'b0, 1'b1, n_ivp);
                cnt = cnt + 2'd1;
            end
        end
        if (eob) begin
            n_ivp   = 1'b0;
            n_phase = PH_NONE;
            n_held  = 8'h00;
            n_ne    = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ivp   <= 1'b0;
            r_phase <= PH_NONE;
            r_held  <= 8'h00;
            r_ne    <= 1'b0;
        end else if (i_accept) begin
            r_ivp   <= n_ivp;
            r_phase <= n_phase;
            r_held  <= n_held;
            r_ne    <= n_ne;
        end
    end

    assign o_bvalid        = i_accept && (cnt != 2'd0);
    assign o_bundle.slots  = slots;
    assign o_bundle.cnt    = cnt;
    assign o_bundle.eob    = eob;

    // body end returns all pair state to reset
    a_eob_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && eob |=> !r_ivp && r_phase == PH_NONE && !r_ne)
        else $error("state not cleared after body end");

    // a non-delimiter byte of a body that goes on leaves the pair non-empty
    a_pair_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !eob && b != CH_AMP |=> r_ne)
        else $error("pair not marked non-empty");

endmodule

// ===== sv/fue_queue.sv =====
// ----------------------------------------------------------------------------
// fue_queue
// Short queue of result bundles between the front and the back.
// ----------------------------------------------------------------------------
module fue_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  fue_pkg::t_bundle i_wdata,
    input  logic             i_rd,
    output fue_pkg::t_bundle o_head,
    output logic             o_full,
    output logic             o_empty
);
    import fue_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_bundle         r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            wr_en;
    logic            rd_en;

    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_full  = (r_cnt == FULL);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // the front never writes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("bundle written into full queue");

endmodule

// ===== sv/fue_back.sv =====
// ----------------------------------------------------------------------------
// fue_back
// Takes bundles from the queue and hands out their results one item per
// cycle, while the output is popped, through an output register.
// ----------------------------------------------------------------------------
module fue_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fue_pkg::t_bundle   i_head,
    input  logic               i_qempty,
    output logic               o_qpop,
    input  logic               i_pop,
    output logic               o_empty,
    output fue_pkg::t_out_item o_result
);
    import fue_pkg::*;

    logic [1:0] r_idx;
    logic       r_vld;
    t_out_item  r_out;
    logic       load;
    logic       take;
    logic       last;
    t_slot      cur;

    assign load = !r_vld || i_pop;
    assign take = load && !i_qempty;
    assign cur  = i_head.slots[r_idx];
    assign last = (r_idx == i_head.cnt - 2'd1);

    assign o_qpop   = take && last;
    assign o_empty  = !r_vld;
    assign o_result = r_out;

    // slot index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= !i_qempty;
            if (take) begin
                r_idx <= last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.out_byte  <= cur.data;
            r_out.is_value  <= cur.val;
            r_out.pair_end  <= cur.marker;
            r_out.pair_kept <= cur.kept;
            r_out.body_end  <= last && i_head.eob;
            r_out.run_last  <= last;
        end
    end

    // the slot index stays inside the head bundle
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_qempty |-> r_idx < i_head.cnt)
        else $error("slot index past bundle end");

    // index returns to zero after the head bundle leaves
    a_idx_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_qpop |=> r_idx == 2'd0)
        else $error("slot index not rewound");

endmodule
